### src/sxl_pkg.sv
// ----------------------------------------------------------------------------
// sxl_pkg
// Shared types and codes of the s-expression lexer: result items, the
// per-byte bundle of results and queue status.
// ----------------------------------------------------------------------------
package sxl_pkg;

  localparam int MaxRes     = 4;
  localparam int QueueDepth = 4;

  localparam logic [2:0] ITEM_CHAR    = 3'd0;
  localparam logic [2:0] ITEM_END     = 3'd1;
  localparam logic [2:0] ITEM_OPEN    = 3'd2;
  localparam logic [2:0] ITEM_CLOSE   = 3'd3;
  localparam logic [2:0] ITEM_DISCARD = 3'd4;
  localparam logic [2:0] ITEM_INEND   = 3'd5;

  localparam logic [1:0] KIND_NUM = 2'd0;
  localparam logic [1:0] KIND_SYM = 2'd1;
  localparam logic [1:0] KIND_STR = 2'd2;

  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_SLASH  = 8'h2f;

  typedef struct packed {
    logic [2:0] item_type;
    logic [1:0] token_kind;
    logic [7:0] ch;
    logic       run_last;
  } item_t;

  typedef struct packed {
    logic [2:0] cnt;
    item_t [MaxRes-1:0] items;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### src/sxl_front.sv
// ----------------------------------------------------------------------------
// sxl_front
// Lexer mode register and byte classifier; builds the bundle of results
// that one source byte causes.
// ----------------------------------------------------------------------------
module sxl_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       char_value,
  input  logic             is_last,
  input  logic             accept,
  output sxl_pkg::bundle_t bundle
);
  import sxl_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_STR  = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_INT  = 3'd3,
    MODE_FRAC = 3'd4,
    MODE_NEG  = 3'd5,
    MODE_WORD = 3'd6
  } mode_t;

  typedef struct packed {
    logic  emit;
    item_t item;
    mode_t mode;
    logic  again;
  } step_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return ((c >= 8'd65) && (c <= 8'd90)) || ((c >= 8'd97) && (c <= 8'd122)) ||
           c == CH_UNDER || c == CH_MINUS || c == CH_PLUS ||
           c == CH_STAR || c == CH_SLASH;
  endfunction

  function automatic item_t mk(input logic [2:0] t, input logic [1:0] k,
                               input logic [7:0] c);
    item_t it;
    it.item_type  = t;
    it.token_kind = k;
    it.ch         = c;
    it.run_last   = 1'b0;
    return it;
  endfunction

  function automatic step_t lex_step(input mode_t m, input logic [7:0] c);
    step_t s;
    s.emit  = 1'b0;
    s.item  = mk(ITEM_CHAR, KIND_NUM, 8'd0);
    s.mode  = m;
    s.again = 1'b0;
    case (m)
      MODE_STR: begin
        if (c == CH_BSLASH) begin
          s.mode = MODE_ESC;
        end else if (c == CH_QUOTE) begin
          s.emit = 1'b1;
          s.item = mk(ITEM_END, KIND_STR, 8'd0);
          s.mode = MODE_IDLE;
        end else begin
          s.emit = 1'b1;
          s.item = mk(ITEM_CHAR, KIND_STR, c);
        end
      end
      MODE_ESC: begin
        s.emit = 1'b1;
        s.item = mk(ITEM_CHAR, KIND_STR, c);
        s.mode = MODE_STR;
      end
      MODE_INT: begin
        s.emit = 1'b1;
        if (is_digit(c)) begin
          s.item = mk(ITEM_CHAR, KIND_NUM, c);
        end else if (c == CH_DOT) begin
          s.item = mk(ITEM_CHAR, KIND_NUM, c);
          s.mode = MODE_FRAC;
        end else begin
          s.item  = mk(ITEM_END, KIND_NUM, 8'd0);
          s.mode  = MODE_IDLE;
          s.again = 1'b1;
        end
      end
      MODE_FRAC: begin
        s.emit = 1'b1;
        if (is_digit(c)) begin
          s.item = mk(ITEM_CHAR, KIND_NUM, c);
        end else begin
          s.item  = mk(ITEM_END, KIND_NUM, 8'd0);
          s.mode  = MODE_IDLE;
          s.again = 1'b1;
        end
      end
      MODE_NEG: begin
        s.emit  = 1'b1;
        s.again = 1'b1;
        if (is_digit(c)) begin
          s.item = mk(ITEM_CHAR, KIND_NUM, CH_MINUS);
          s.mode = MODE_INT;
        end else begin
          s.item = mk(ITEM_CHAR, KIND_SYM, CH_MINUS);
          s.mode = MODE_WORD;
        end
      end
      MODE_WORD: begin
        s.emit = 1'b1;
        if (is_word(c)) begin
          s.item = mk(ITEM_CHAR, KIND_SYM, c);
        end else begin
          s.item  = mk(ITEM_END, KIND_SYM, 8'd0);
          s.mode  = MODE_IDLE;
          s.again = 1'b1;
        end
      end
      default: begin
        s.mode = MODE_IDLE;
        if (c == CH_MINUS) begin
          s.mode = MODE_NEG;
        end else if (c == CH_SPACE) begin
          s.mode = MODE_IDLE;
        end else if (c == CH_QUOTE) begin
          s.mode = MODE_STR;
        end else if (c == CH_OPEN) begin
          s.emit = 1'b1;
          s.item = mk(ITEM_OPEN, KIND_NUM, 8'd0);
        end else if (c == CH_CLOSE) begin
          s.emit = 1'b1;
          s.item = mk(ITEM_CLOSE, KIND_NUM, 8'd0);
        end else if (is_digit(c)) begin
          s.emit = 1'b1;
          s.item = mk(ITEM_CHAR, KIND_NUM, c);
          s.mode = MODE_INT;
        end else if (is_word(c)) begin
          s.emit = 1'b1;
          s.item = mk(ITEM_CHAR, KIND_SYM, c);
          s.mode = MODE_WORD;
        end
      end
    endcase
    return s;
  endfunction

  mode_t mode_r, mode_nxt;
  item_t [MaxRes:0] list;
  logic  [2:0]      n;
  logic  [2:0]      cnt;
  step_t            st;
  logic             again;

  always_comb begin
    mode_nxt = mode_r;
    list     = '0;
    n        = 3'd0;
    again    = 1'b1;
    st       = '0;
    // at most three passes: pending minus, number or word, then idle
    for (int k = 0; k < 3; k++) begin
      if (again) begin
        st = lex_step(mode_nxt, char_value);
        if (st.emit) begin
          list[n] = st.item;
          n       = n + 3'd1;
        end
        mode_nxt = st.mode;
        again    = st.again;
      end
    end
    if (is_last) begin
      case (mode_nxt)
        MODE_INT, MODE_FRAC: begin
          list[n] = mk(ITEM_END, KIND_NUM, 8'd0);
          n       = n + 3'd1;
        end
        MODE_WORD: begin
          list[n] = mk(ITEM_END, KIND_SYM, 8'd0);
          n       = n + 3'd1;
        end
        MODE_NEG: begin
          list[n] = mk(ITEM_CHAR, KIND_SYM, CH_MINUS);
          n       = n + 3'd1;
          list[n] = mk(ITEM_END, KIND_SYM, 8'd0);
          n       = n + 3'd1;
        end
        MODE_STR, MODE_ESC: begin
          list[n] = mk(ITEM_DISCARD, KIND_STR, 8'd0);
          n       = n + 3'd1;
        end
        default: begin
        end
      endcase
      if (n < 3'd5) begin
        list[n] = mk(ITEM_INEND, KIND_NUM, 8'd0);
        n       = n + 3'd1;
      end
      mode_nxt = MODE_IDLE;
    end
    // anything past the fourth result is lost
    cnt = (n > 3'(MaxRes)) ? 3'(MaxRes) : n;
    if (cnt != 3'd0) begin
      list[cnt - 3'd1].run_last = 1'b1;
    end
    bundle.cnt = cnt;
    for (int k = 0; k < MaxRes; k++) begin
      bundle.items[k] = list[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
    end else if (accept) begin
      mode_r <= mode_nxt;
    end
  end

endmodule

### src/sxl_queue.sv
// ----------------------------------------------------------------------------
// sxl_queue
// Short queue of result bundles between the classifier and the serializer.
// ----------------------------------------------------------------------------
module sxl_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sxl_pkg::bundle_t wr_data,
  input  logic             pop,
  output sxl_pkg::bundle_t rd_data,
  output sxl_pkg::q_stat_t stat
);
  import sxl_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  bundle_t             mem [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [PtrW:0]       count_r;

  assign stat.full  = (count_r == (PtrW+1)'(QueueDepth));
  assign stat.empty = (count_r == '0);
  assign rd_data    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PtrW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (PtrW+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (PtrW+1)'(1);
      end
    end
  end

endmodule

### src/sxl_back.sv
// ----------------------------------------------------------------------------
// sxl_back
// Serializer: takes result bundles from the queue and delivers their items
// one a cycle through the output register while out_ready is high.
// ----------------------------------------------------------------------------
module sxl_back (
  input  logic             clk,
  input  logic             rst_n,
  input  sxl_pkg::bundle_t head,
  input  sxl_pkg::q_stat_t stat,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       out_item_type,
  output logic [1:0]       out_token_kind,
  output logic [7:0]       out_out_char,
  output logic             out_run_last
);
  import sxl_pkg::*;

  localparam int IdxW = $clog2(MaxRes);

  logic [IdxW-1:0] idx_r;
  logic            valid_r;
  item_t           item_r;
  logic            load;
  logic            at_end;

  assign load   = !stat.empty && (!valid_r || out_ready);
  assign at_end = ({1'b0, idx_r} == (head.cnt - 3'd1));
  assign pop    = load && at_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= at_end ? '0 : idx_r + IdxW'(1);
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= head.items[idx_r];
    end
  end

  assign out_valid      = valid_r;
  assign out_item_type  = item_r.item_type;
  assign out_token_kind = item_r.token_kind;
  assign out_out_char   = item_r.ch;
  assign out_run_last   = item_r.run_last;

`ifndef NO_ASSERTIONS
  // serializer index only moves while a bundle is present
  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    stat.empty |-> (idx_r == '0))
    else $error("serializer index not at zero with empty queue");

  // stalled result is not replaced
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_ready) |=> (valid_r && $stable(item_r)))
    else $error("result changed while stalled");

  // a bundle is never popped before its last item is loaded
  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> item_r.run_last)
    else $error("bundle popped without its final item");

  // item codes stay in range
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (item_r.item_type <= ITEM_INEND))
    else $error("item code out of range");
`endif

endmodule

### src/sexpr_lexer_unit.sv
// ----------------------------------------------------------------------------
// sexpr_lexer_unit
// S-expression tokenizer: one source byte per request in, a stream of token
// char, token end, paren, discard and input end items out.
// ----------------------------------------------------------------------------
// A byte is taken in every cycle while the bundle queue (four entries) has
// room; the classifier settles the lexer mode in the same cycle, so bytes can
// follow back to back. Each byte yields zero to four results, which leave one
// a cycle through the output register while out_ready is high; the output
// side sets the sustained rate.
module sexpr_lexer_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_value,
  input  logic       in_is_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_item_type,
  output logic [1:0] out_token_kind,
  output logic [7:0] out_out_char,
  output logic       out_run_last
);
  import sxl_pkg::*;

  bundle_t bundle;
  bundle_t head;
  q_stat_t stat;
  logic    accept;
  logic    push;
  logic    pop;

  assign in_ready = !stat.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (bundle.cnt != 3'd0);

  sxl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .char_value (in_char_value),
    .is_last    (in_is_last),
    .accept     (accept),
    .bundle     (bundle)
  );

  sxl_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (bundle),
    .pop     (pop),
    .rd_data (head),
    .stat    (stat)
  );

  sxl_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .stat           (stat),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_item_type  (out_item_type),
    .out_token_kind (out_token_kind),
    .out_out_char   (out_out_char),
    .out_run_last   (out_run_last)
  );

endmodule
